// ===== sv/rgbrop_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbrop_pkg
// Shared types and constants for the RGB565 raster-op ALU.
// ----------------------------------------------------------------------------
package rgbrop_pkg;

  localparam int PIX_W = 16;
  localparam int OP_W  = 5;
  localparam int R_W   = 5;
  localparam int G_W   = 6;
  localparam int B_W   = 5;

  localparam logic [R_W-1:0]   R_MAX = 5'h1F;
  localparam logic [G_W-1:0]   G_MAX = 6'h3F;
  localparam logic [B_W-1:0]   B_MAX = 5'h1F;
  localparam logic [PIX_W-1:0] PIX_ONES = 16'hFFFF;
  localparam logic [PIX_W-1:0] PIX_ZERO = 16'h0000;
  localparam logic [PIX_W-1:0] MASK_THRESHOLD_RESET = 16'h7BEF;

  localparam logic [OP_W-1:0] OP_BLACK       = 5'd0;
  localparam logic [OP_W-1:0] OP_MERGECOPY   = 5'd1;
  localparam logic [OP_W-1:0] OP_MERGEPAINT  = 5'd2;
  localparam logic [OP_W-1:0] OP_NOTSRCCOPY  = 5'd3;
  localparam logic [OP_W-1:0] OP_NOTSRCERASE = 5'd4;
  localparam logic [OP_W-1:0] OP_PATCOPY     = 5'd5;
  localparam logic [OP_W-1:0] OP_PATINVERT   = 5'd6;
  localparam logic [OP_W-1:0] OP_PATPAINT    = 5'd7;
  localparam logic [OP_W-1:0] OP_SRCAND      = 5'd8;
  localparam logic [OP_W-1:0] OP_SRCCOPY     = 5'd9;
  localparam logic [OP_W-1:0] OP_SRCERASE    = 5'd10;
  localparam logic [OP_W-1:0] OP_SRCINVERT   = 5'd11;
  localparam logic [OP_W-1:0] OP_SRCPAINT    = 5'd12;
  localparam logic [OP_W-1:0] OP_WHITE       = 5'd13;
  localparam logic [OP_W-1:0] OP_ADD         = 5'd14;
  localparam logic [OP_W-1:0] OP_SUB         = 5'd15;
  localparam logic [OP_W-1:0] OP_BLEND       = 5'd16;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [PIX_W-1:0] dest_pixel;
    logic [PIX_W-1:0] src_pixel;
    logic [PIX_W-1:0] mask_pixel;
    logic             invert;
  } pix_item_t;

endpackage

// ===== sv/rgbrop_alu.sv =====
// ----------------------------------------------------------------------------
// rgbrop_alu
// Combinational raster-op and per-channel arithmetic on one RGB565 pixel.
// ----------------------------------------------------------------------------
module rgbrop_alu (
  input  rgbrop_pkg::pix_item_t          item,
  input  logic [rgbrop_pkg::PIX_W-1:0]   mask_threshold,
  output logic [rgbrop_pkg::PIX_W-1:0]   result_pixel
);

  logic [rgbrop_pkg::PIX_W-1:0] d;
  logic [rgbrop_pkg::PIX_W-1:0] s;
  logic [rgbrop_pkg::PIX_W-1:0] m;

  logic [rgbrop_pkg::R_W-1:0] dr, sr, add_r, sub_r, bl_r;
  logic [rgbrop_pkg::G_W-1:0] dg, sg, add_g, sub_g, bl_g;
  logic [rgbrop_pkg::B_W-1:0] db, sb, add_b, sub_b, bl_b;
  logic [rgbrop_pkg::R_W:0]   sum_r;
  logic [rgbrop_pkg::G_W:0]   sum_g;
  logic [rgbrop_pkg::B_W:0]   sum_b;

  assign d = item.dest_pixel;
  assign s = item.invert ? ~item.src_pixel : item.src_pixel;
  assign m = (item.mask_pixel > mask_threshold) ? rgbrop_pkg::PIX_ONES : rgbrop_pkg::PIX_ZERO;

  assign dr = d[15:11];
  assign dg = d[10:5];
  assign db = d[4:0];
  assign sr = s[15:11];
  assign sg = s[10:5];
  assign sb = s[4:0];

  // saturating add
  assign sum_r = {1'b0, dr} + {1'b0, sr};
  assign sum_g = {1'b0, dg} + {1'b0, sg};
  assign sum_b = {1'b0, db} + {1'b0, sb};
  assign add_r = sum_r[rgbrop_pkg::R_W] ? rgbrop_pkg::R_MAX : sum_r[rgbrop_pkg::R_W-1:0];
  assign add_g = sum_g[rgbrop_pkg::G_W] ? rgbrop_pkg::G_MAX : sum_g[rgbrop_pkg::G_W-1:0];
  assign add_b = sum_b[rgbrop_pkg::B_W] ? rgbrop_pkg::B_MAX : sum_b[rgbrop_pkg::B_W-1:0];

  // subtract clamped at zero
  assign sub_r = (dr > sr) ? (dr - sr) : '0;
  assign sub_g = (dg > sg) ? (dg - sg) : '0;
  assign sub_b = (db > sb) ? (db - sb) : '0;

  // 50% blend
  assign bl_r = (dr >> 1) + (sr >> 1);
  assign bl_g = (dg >> 1) + (sg >> 1);
  assign bl_b = (db >> 1) + (sb >> 1);

  always_comb begin
    case (item.op)
      rgbrop_pkg::OP_BLACK:       result_pixel = rgbrop_pkg::PIX_ZERO;
      rgbrop_pkg::OP_MERGECOPY:   result_pixel = (m != rgbrop_pkg::PIX_ZERO) ? s : d;
      rgbrop_pkg::OP_MERGEPAINT:  result_pixel = d | ~s;
      rgbrop_pkg::OP_NOTSRCCOPY:  result_pixel = ~s;
      rgbrop_pkg::OP_NOTSRCERASE: result_pixel = ~(d | s);
      rgbrop_pkg::OP_PATCOPY:     result_pixel = d | m;
      rgbrop_pkg::OP_PATINVERT:   result_pixel = d ^ m;
      rgbrop_pkg::OP_PATPAINT:    result_pixel = d | ~s | m;
      rgbrop_pkg::OP_SRCAND:      result_pixel = d & item.src_pixel;
      rgbrop_pkg::OP_SRCCOPY:     result_pixel = s;
      rgbrop_pkg::OP_SRCERASE:    result_pixel = ~d & s;
      rgbrop_pkg::OP_SRCINVERT:   result_pixel = d ^ s;
      rgbrop_pkg::OP_SRCPAINT:    result_pixel = d | s;
      rgbrop_pkg::OP_WHITE:       result_pixel = rgbrop_pkg::PIX_ONES;
      rgbrop_pkg::OP_ADD:         result_pixel = {add_r, add_g, add_b};
      rgbrop_pkg::OP_SUB:         result_pixel = {sub_r, sub_g, sub_b};
      rgbrop_pkg::OP_BLEND:       result_pixel = {bl_r, bl_g, bl_b};
      default:                    result_pixel = d;
    endcase
  end

endmodule

// ===== sv/rgb565_raster_op_alu_core.sv =====
// ----------------------------------------------------------------------------
// rgb565_raster_op_alu_core
// Per-pixel blit ALU for RGB565 pixels.
//
// Usage:
//   An input transaction is taken on a rising edge with start high and busy
//   low; op, dest_pixel, src_pixel, mask_pixel and invert are sampled there.
//   busy is low whenever rst is low, so one pixel can enter every cycle.
//   The result appears on result_pixel with done high for exactly one cycle,
//   after the input register, then the result register around one pass of
//   combinational ALU logic. Throughput is one pixel per clock. The receiver
//   cannot stall: each result must be taken in the cycle it is shown.
//   mask_threshold is written through cfg_valid / cfg_ready / cfg_data and
//   should only be changed while no pixel is in flight. cfg_ready is high
//   outside reset.
//   Synchronous reset rst clears the pipeline valid flags, drops done and
//   loads mask_threshold with 0x7BEF.
// ----------------------------------------------------------------------------
module rgb565_raster_op_alu_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [rgbrop_pkg::OP_W-1:0]    op,
  input  logic [rgbrop_pkg::PIX_W-1:0]   dest_pixel,
  input  logic [rgbrop_pkg::PIX_W-1:0]   src_pixel,
  input  logic [rgbrop_pkg::PIX_W-1:0]   mask_pixel,
  input  logic                           invert,
  output logic                           done,
  output logic [rgbrop_pkg::PIX_W-1:0]   result_pixel,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rgbrop_pkg::PIX_W-1:0]   cfg_data
);

  rgbrop_pkg::pix_item_t        item;
  logic                         item_valid;
  logic [rgbrop_pkg::PIX_W-1:0] mask_threshold;
  logic [rgbrop_pkg::PIX_W-1:0] alu_result;
  logic                         accept;

  assign busy      = rst;
  assign cfg_ready = !rst;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_threshold <= rgbrop_pkg::MASK_THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      mask_threshold <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.op         <= op;
      item.dest_pixel <= dest_pixel;
      item.src_pixel  <= src_pixel;
      item.mask_pixel <= mask_pixel;
      item.invert     <= invert;
    end
  end

  rgbrop_alu u_alu (
    .item           (item),
    .mask_threshold (mask_threshold),
    .result_pixel   (alu_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid) begin
      result_pixel <= alu_result;
    end
  end

endmodule

// ===== sv/rgbrop_checker.sv =====
// ----------------------------------------------------------------------------
// rgbrop_checker
// Port-level checks on latency and a few fixed results of the blit ALU.
// ----------------------------------------------------------------------------
module rgbrop_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic [rgbrop_pkg::OP_W-1:0]    op,
  input logic [rgbrop_pkg::PIX_W-1:0]   src_pixel,
  input logic                           invert,
  input logic                           done,
  input logic [rgbrop_pkg::PIX_W-1:0]   result_pixel
);

  // every accepted transaction produces a result strobe on done
  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted transaction produced no result");

  // no result without a transaction
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without a transaction");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe after reset");

  a_srccopy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == rgbrop_pkg::OP_SRCCOPY && !invert)
      |-> ##2 (result_pixel == $past(src_pixel, 2)))
    else $error("srccopy result differs from source");

  a_white: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == rgbrop_pkg::OP_WHITE)
      |-> ##2 (result_pixel == rgbrop_pkg::PIX_ONES))
    else $error("white result is not all ones");

endmodule

bind rgb565_raster_op_alu_core rgbrop_checker u_rgbrop_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .op           (op),
  .src_pixel    (src_pixel),
  .invert       (invert),
  .done         (done),
  .result_pixel (result_pixel)
);
